[src/ncse_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package ncse_pkg;
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_OUTSIDE = 2'd1,
		ST_ZERO    = 2'd2
	} status_t;
	localparam int IN_FIELDS = 9;
	localparam int FIELD_W = 32;
endpackage
`default_nettype wire

[src/nonuniform_cubic_spline_eval_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// Non-uniform cubic interpolation in Newton form, signed fixed point.
// Input channel s_axis: one transfer carries four samples, four knot times
// and the query time. Output channel m_axis: one transfer per input with the
// saturated value, status and a saturation flag.
// The datapath is one pipeline stalled as a whole: differences, three levels
// of pipelined dividers (DATA_WIDTH+FRAC_BITS stages each) and three
// multiply-add steps; throughput is one item per cycle while the output is not stalled.
// s_axis_tready is high while the output register is empty or being taken,
// so an item enters every cycle unless the receiver stalls; a stall freezes
// every stage and loses nothing.
// Reset clears all valid bits; payload registers keep whatever they held.
module nonuniform_cubic_spline_eval_core #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_axis_tvalid,
	output logic              s_axis_tready,
	// sample0..3, knot0..3, query_time (32 bits each, lowest first)
	input  wire logic [287:0] s_axis_tdata,
	output logic              m_axis_tvalid,
	input  wire logic         m_axis_tready,
	// value[31:0], status[33:32], saturated[34], zero fill
	output logic [39:0]       m_axis_tdata
);
	import ncse_pkg::*;
	localparam int W = DATA_WIDTH;
	localparam int DL = W + FRAC_BITS;
	localparam int NS = 3 * DL + 14;
	localparam logic signed [W-1:0] MAXW = {1'b0, {(W-1){1'b1}}};
	localparam logic signed [W-1:0] MINW = {1'b1, {(W-1){1'b0}}};

	typedef logic signed [W-1:0] w_t;

	// global stall
	logic en;
	assign en = ~m_axis_tvalid | m_axis_tready;
	assign s_axis_tready = en;

	logic v_q [NS+1];
	assign v_q[0] = s_axis_tvalid;
	for (genvar i = 0; i < NS; i++) begin : g_v
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_q[i+1] <= 1'b0;
			else if (en) v_q[i+1] <= v_q[i];
		end
	end
	assign m_axis_tvalid = v_q[NS];

	// clamp a 32-bit input to W bits
	function automatic w_t clampin(input logic signed [31:0] x, output logic c);
		logic signed [64:0] e;
		e = 65'(x);
		c = 1'b0;
		if (e > 65'(MAXW)) begin c = 1'b1; return MAXW; end
		if (e < 65'(MINW)) begin c = 1'b1; return MINW; end
		return w_t'(e);
	endfunction

	function automatic w_t sat_add(input w_t a, input w_t b, output logic c);
		logic signed [W:0] s;
		s = (W+1)'(a) + (W+1)'(b);
		c = s[W] ^ s[W-1];
		return c ? (s[W] ? MINW : MAXW) : s[W-1:0];
	endfunction

	function automatic w_t sat_sub(input w_t a, input w_t b, output logic c);
		logic signed [W:0] s;
		s = (W+1)'(a) - (W+1)'(b);
		c = s[W] ^ s[W-1];
		return c ? (s[W] ? MINW : MAXW) : s[W-1:0];
	endfunction

	// unsigned magnitude; the most negative value maps to 2^(W-1)
	function automatic logic [W-1:0] magn(input w_t a);
		return a[W-1] ? W'(-a) : W'(a);
	endfunction

	// product magnitude >> FRAC_BITS, signed, saturated
	function automatic w_t mul_fin(input logic [2*W-1:0] p, input logic ng,
		output logic c);
		logic [2*W-1:0] q;
		logic [2*W:0]   lim;
		q = p >> FRAC_BITS;
		lim = (2*W+1)'(MAXW) + (2*W+1)'(ng);
		c = 1'b0;
		if ({1'b0, q} > lim) begin c = 1'b1; return ng ? MINW : MAXW; end
		return ng ? w_t'(-q[W-1:0]) : w_t'(q[W-1:0]);
	endfunction

	// stage 1: clamp inputs, status range compare
	w_t f_s1 [4], t_s1 [4], q_s1;
	logic c_s1, out_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			logic c [9];
			logic signed [31:0] x;
			for (int k = 0; k < 4; k++) begin
				f_s1[k] <= clampin(s_axis_tdata[k*32 +: 32], c[k]);
				t_s1[k] <= clampin(s_axis_tdata[(k+4)*32 +: 32], c[k+4]);
			end
			q_s1 <= clampin(s_axis_tdata[256 +: 32], c[8]);
			c_s1 <= c[0] | c[1] | c[2] | c[3] | c[4] | c[5] | c[6] | c[7] | c[8];
			x = s_axis_tdata[256 +: 32];
			out_s1 <= (x < $signed(s_axis_tdata[128 +: 32]))
				| (x > $signed(s_axis_tdata[224 +: 32]));
		end
	end

	// stage 2: first differences and wider knot spans
	w_t n1_s2 [3], d1_s2 [3], dd_s2 [3], f0_s2, q_s2, tt_s2 [4];
	logic c_s2, out_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			logic c [9];
			n1_s2[0] <= sat_sub(f_s1[1], f_s1[0], c[0]);
			n1_s2[1] <= sat_sub(f_s1[2], f_s1[1], c[1]);
			n1_s2[2] <= sat_sub(f_s1[3], f_s1[2], c[2]);
			d1_s2[0] <= sat_sub(t_s1[1], t_s1[0], c[3]);
			d1_s2[1] <= sat_sub(t_s1[2], t_s1[1], c[4]);
			d1_s2[2] <= sat_sub(t_s1[3], t_s1[2], c[5]);
			dd_s2[0] <= sat_sub(t_s1[2], t_s1[0], c[6]);
			dd_s2[1] <= sat_sub(t_s1[3], t_s1[1], c[7]);
			dd_s2[2] <= sat_sub(t_s1[3], t_s1[0], c[8]);
			f0_s2 <= f_s1[0];
			q_s2 <= q_s1;
			tt_s2 <= t_s1;
			c_s2 <= c_s1 | c[0] | c[1] | c[2] | c[3] | c[4] | c[5] | c[6] | c[7] | c[8];
			out_s2 <= out_s1;
		end
	end

	// side channel delay lines along the divider levels
	typedef struct packed {
		logic signed [W-1:0] f0;
		logic signed [W-1:0] q;
		logic signed [W-1:0] t0;
		logic signed [W-1:0] t1;
		logic signed [W-1:0] t2;
		logic signed [W-1:0] dd1;
		logic signed [W-1:0] dd2;
		logic c;
		logic o;
	} side_t;

	// level 1 dividers
	w_t g1 [3];
	logic gc1 [3], gz1 [3];
	for (genvar k = 0; k < 3; k++) begin : g_l1
		ncse_div #(.W(W), .FRAC_BITS(FRAC_BITS)) u_div (
			.clk(clk), .en(en),
			.num(n1_s2[k]), .den(d1_s2[k]),
			.quo(g1[k]), .clip(gc1[k]), .zero(gz1[k]));
	end
	side_t sd1 [DL+1];
	assign sd1[0] = '{f0: f0_s2, q: q_s2, t0: tt_s2[0], t1: tt_s2[1], t2: tt_s2[2],
		dd1: dd_s2[1], dd2: dd_s2[2], c: c_s2, o: out_s2};
	w_t dd0_d [DL+1];
	assign dd0_d[0] = dd_s2[0];
	for (genvar i = 0; i < DL; i++) begin : g_sd1
		always_ff @(posedge clk) if (en) begin
			sd1[i+1] <= sd1[i];
			dd0_d[i+1] <= dd0_d[i];
		end
	end

	// stage 3: second-level numerators
	w_t n2_s3 [2], f1_s3, dd0_s3;
	side_t sd_s3;
	logic z_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			logic c0, c1;
			side_t sd;
			n2_s3[0] <= sat_sub(g1[1], g1[0], c0);
			n2_s3[1] <= sat_sub(g1[2], g1[1], c1);
			f1_s3 <= g1[0];
			dd0_s3 <= dd0_d[DL];
			sd = sd1[DL];
			sd.c = sd1[DL].c | gc1[0] | gc1[1] | gc1[2] | c0 | c1;
			sd_s3 <= sd;
			z_s3 <= gz1[0] | gz1[1] | gz1[2];
		end
	end

	// level 2 dividers: (f2-f1)/(t2-t0), (f3-f2)/(t3-t1)
	w_t g2 [2];
	logic gc2 [2], gz2 [2];
	ncse_div #(.W(W), .FRAC_BITS(FRAC_BITS)) u_div2a (
		.clk(clk), .en(en), .num(n2_s3[0]), .den(dd0_s3),
		.quo(g2[0]), .clip(gc2[0]), .zero(gz2[0]));
	ncse_div #(.W(W), .FRAC_BITS(FRAC_BITS)) u_div2b (
		.clk(clk), .en(en), .num(n2_s3[1]), .den(sd_s3.dd1),
		.quo(g2[1]), .clip(gc2[1]), .zero(gz2[1]));
	side_t sd2 [DL+1];
	w_t f1_d2 [DL+1];
	logic z_d2 [DL+1];
	assign sd2[0] = sd_s3;
	assign f1_d2[0] = f1_s3;
	assign z_d2[0] = z_s3;
	for (genvar i = 0; i < DL; i++) begin : g_sd2
		always_ff @(posedge clk) if (en) begin
			sd2[i+1] <= sd2[i];
			f1_d2[i+1] <= f1_d2[i];
			z_d2[i+1] <= z_d2[i];
		end
	end

	// stage 4: third-level numerator
	w_t n3_s4, f2_s4, f1_s4;
	side_t sd_s4;
	logic z_s4;
	always_ff @(posedge clk) begin
		if (en) begin
			logic c0;
			side_t sd;
			n3_s4 <= sat_sub(g2[1], g2[0], c0);
			f2_s4 <= g2[0];
			f1_s4 <= f1_d2[DL];
			sd = sd2[DL];
			sd.c = sd2[DL].c | gc2[0] | gc2[1] | c0;
			sd_s4 <= sd;
			z_s4 <= z_d2[DL] | gz2[0] | gz2[1];
		end
	end

	// level 3 divider
	w_t g3;
	logic gc3, gz3;
	ncse_div #(.W(W), .FRAC_BITS(FRAC_BITS)) u_div3 (
		.clk(clk), .en(en), .num(n3_s4), .den(sd_s4.dd2),
		.quo(g3), .clip(gc3), .zero(gz3));
	side_t sd3 [DL+1];
	w_t f2_d3 [DL+1], f1_d3 [DL+1];
	logic z_d3 [DL+1];
	assign sd3[0] = sd_s4;
	assign f2_d3[0] = f2_s4;
	assign f1_d3[0] = f1_s4;
	assign z_d3[0] = z_s4;
	for (genvar i = 0; i < DL; i++) begin : g_sd3
		always_ff @(posedge clk) if (en) begin
			sd3[i+1] <= sd3[i];
			f2_d3[i+1] <= f2_d3[i];
			f1_d3[i+1] <= f1_d3[i];
			z_d3[i+1] <= z_d3[i];
		end
	end

	// Horner steps: each is sub (e1), multiply (e2), shift+add (e3)
	typedef struct packed {
		logic signed [W-1:0] f1;
		logic signed [W-1:0] f0;
		logic signed [W-1:0] q;
		logic signed [W-1:0] t0;
		logic signed [W-1:0] t1;
		logic c;
		logic z;
		logic o;
	} hs_t;

	// step A: acc = f2 + (t - t2) * f3
	w_t xa_e1, ya_e1, ka_e1, ka_e2;
	hs_t ha_e1, ha_e2, ha_e3;
	logic [2*W-1:0] pa_e2;
	logic nga_e2;
	w_t acca_e3;
	always_ff @(posedge clk) begin
		if (en) begin
			logic c0;
			xa_e1 <= sat_sub(sd3[DL].q, sd3[DL].t2, c0);
			ya_e1 <= g3;
			ka_e1 <= f2_d3[DL];
			ha_e1 <= '{f1: f1_d3[DL], f0: sd3[DL].f0, q: sd3[DL].q, t0: sd3[DL].t0,
				t1: sd3[DL].t1, c: sd3[DL].c | gc3 | c0, z: z_d3[DL] | gz3, o: sd3[DL].o};
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			pa_e2 <= (2*W)'(magn(xa_e1)) * (2*W)'(magn(ya_e1));
			nga_e2 <= xa_e1[W-1] ^ ya_e1[W-1];
			ka_e2 <= ka_e1;
			ha_e2 <= ha_e1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			logic c0, c1;
			w_t m;
			hs_t h;
			m = mul_fin(pa_e2, nga_e2, c0);
			acca_e3 <= sat_add(ka_e2, m, c1);
			h = ha_e2;
			h.c = ha_e2.c | c0 | c1;
			ha_e3 <= h;
		end
	end

	// step B: acc = f1 + (t - t1) * acc
	w_t xb_e1, yb_e1, kb_e1, kb_e2, accb_e3;
	hs_t hb_e1, hb_e2, hb_e3;
	logic [2*W-1:0] pb_e2;
	logic ngb_e2;
	always_ff @(posedge clk) begin
		if (en) begin
			logic c0;
			hs_t h;
			xb_e1 <= sat_sub(ha_e3.q, ha_e3.t1, c0);
			yb_e1 <= acca_e3;
			kb_e1 <= ha_e3.f1;
			h = ha_e3;
			h.c = ha_e3.c | c0;
			hb_e1 <= h;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			pb_e2 <= (2*W)'(magn(xb_e1)) * (2*W)'(magn(yb_e1));
			ngb_e2 <= xb_e1[W-1] ^ yb_e1[W-1];
			kb_e2 <= kb_e1;
			hb_e2 <= hb_e1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			logic c0, c1;
			w_t m;
			hs_t h;
			m = mul_fin(pb_e2, ngb_e2, c0);
			accb_e3 <= sat_add(kb_e2, m, c1);
			h = hb_e2;
			h.c = hb_e2.c | c0 | c1;
			hb_e3 <= h;
		end
	end

	// step C: acc = f0 + (t - t0) * acc
	w_t xc_e1, yc_e1, kc_e1, kc_e2, accc_e3;
	hs_t hc_e1, hc_e2, hc_e3;
	logic [2*W-1:0] pc_e2;
	logic ngc_e2;
	always_ff @(posedge clk) begin
		if (en) begin
			logic c0;
			hs_t h;
			xc_e1 <= sat_sub(hb_e3.q, hb_e3.t0, c0);
			yc_e1 <= accb_e3;
			kc_e1 <= hb_e3.f0;
			h = hb_e3;
			h.c = hb_e3.c | c0;
			hc_e1 <= h;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			pc_e2 <= (2*W)'(magn(xc_e1)) * (2*W)'(magn(yc_e1));
			ngc_e2 <= xc_e1[W-1] ^ yc_e1[W-1];
			kc_e2 <= kc_e1;
			hc_e2 <= hc_e1;
		end
	end
	always_ff @(posedge clk) begin
		if (en) begin
			logic c0, c1;
			w_t m;
			hs_t h;
			m = mul_fin(pc_e2, ngc_e2, c0);
			accc_e3 <= sat_add(kc_e2, m, c1);
			h = hc_e2;
			h.c = hc_e2.c | c0 | c1;
			hc_e3 <= h;
		end
	end

	// output register: clamp to 32 bits, form status
	logic [31:0] value_q;
	status_t st_q;
	logic sat_q;
	always_ff @(posedge clk) begin
		if (en) begin
			logic signed [64:0] e;
			e = 65'(accc_e3);
			if (e > 65'sh7FFFFFFF) begin
				value_q <= 32'h7FFFFFFF;
				sat_q <= 1'b1;
			end else if (e < -65'sh80000000) begin
				value_q <= 32'h80000000;
				sat_q <= 1'b1;
			end else begin
				value_q <= e[31:0];
				sat_q <= hc_e3.c;
			end
			if (hc_e3.z) st_q <= ST_ZERO;
			else if (hc_e3.o) st_q <= ST_OUTSIDE;
			else st_q <= ST_OK;
		end
	end
	assign m_axis_tdata = {5'd0, sat_q, st_q, value_q};
endmodule
`default_nettype wire

[src/ncse_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// Pipelined restoring divider: (n << FRAC_BITS) / d on magnitudes, signed result
// saturated to W bits. One quotient bit per stage, so an item enters every cycle while en is high.
module ncse_div #(
	parameter int W = 32,
	parameter int FRAC_BITS = 16
) (
	input  wire logic         clk,
	input  wire logic         en,
	input  wire logic signed [W-1:0] num,
	input  wire logic signed [W-1:0] den,
	output logic signed [W-1:0] quo,
	output logic              clip,
	output logic              zero
);
	localparam int NB = W + FRAC_BITS;
	localparam int ST = NB;
	localparam logic [W:0] MAXV = {2'b00, {(W-1){1'b1}}};

	logic [NB-1:0] n_s [ST+1];
	logic [W-1:0]  d_s [ST+1];
	logic [W:0]    r_s [ST+1];
	logic [NB-1:0] q_s [ST+1];
	logic          ng_s [ST+1];
	logic          dz_s [ST+1];
	logic          nz_s [ST+1];
	logic          np_s [ST+1];

	logic [W-1:0] nmag, dmag;
	assign nmag = num[W-1] ? W'(-num) : W'(num);
	assign dmag = den[W-1] ? W'(-den) : W'(den);

	// load stage 0
	always_comb begin
		n_s[0]  = {nmag, {FRAC_BITS{1'b0}}};
		d_s[0]  = dmag;
		r_s[0]  = '0;
		q_s[0]  = '0;
		ng_s[0] = num[W-1] ^ den[W-1];
		dz_s[0] = (den == '0);
		nz_s[0] = (num == '0);
		np_s[0] = ~num[W-1];
	end

	// one quotient bit per stage
	for (genvar i = 0; i < ST; i++) begin : g_st
		logic [W+1:0] sh;
		logic         ge;
		assign sh = {r_s[i], n_s[i][NB-1]};
		assign ge = sh >= {2'b00, d_s[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				r_s[i+1]  <= ge ? (W+1)'(sh - {2'b00, d_s[i]}) : sh[W:0];
				q_s[i+1]  <= {q_s[i][NB-2:0], ge};
				n_s[i+1]  <= {n_s[i][NB-2:0], 1'b0};
				d_s[i+1]  <= d_s[i];
				ng_s[i+1] <= ng_s[i];
				dz_s[i+1] <= dz_s[i];
				nz_s[i+1] <= nz_s[i];
				np_s[i+1] <= np_s[i];
			end
		end
	end

	// saturate and sign
	logic [NB-1:0] qf;
	logic [NB:0]   lim;
	assign qf  = q_s[ST];
	assign lim = (NB+1)'(MAXV) + (NB+1)'(ng_s[ST]);
	always_comb begin
		zero = dz_s[ST];
		clip = 1'b0;
		quo  = '0;
		if (dz_s[ST]) begin
			clip = ~nz_s[ST];
			if (!nz_s[ST]) quo = np_s[ST] ? W'(MAXV) : {1'b1, {(W-1){1'b0}}};
		end else if ({1'b0, qf} > lim) begin
			clip = 1'b1;
			quo  = ng_s[ST] ? {1'b1, {(W-1){1'b0}}} : W'(MAXV);
		end else begin
			quo = ng_s[ST] ? W'(-qf[W-1:0]) : qf[W-1:0];
		end
	end
endmodule
`default_nettype wire

[src/ncse_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
module ncse_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_axis_tvalid,
	input wire logic         s_axis_tready,
	input wire logic         m_axis_tvalid,
	input wire logic         m_axis_tready,
	input wire logic [39:0]  m_axis_tdata
);
	import ncse_pkg::*;
	// a waiting result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed while stalled");
	// status code 3 never appears
	a_stat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[33:32] != 2'd3)
		else $error("bad status");
	// fill bits are zero
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[39:35] == 5'd0)
		else $error("fill bits set");
	// input is ready whenever the output register is empty
	a_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input blocked with empty output");
endmodule
bind nonuniform_cubic_spline_eval_core ncse_checker u_ncse_checker (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata));
`default_nettype wire

[sim/nonuniform_cubic_spline_eval_core_tb.sv]
`timescale 1ns / 1ps
module nonuniform_cubic_spline_eval_core_tb;
	import ncse_pkg::*;

	localparam int N_RANDOM = 1400;
	localparam int LATENCY = 158;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int TAIL_ITEMS = 150;

	typedef struct packed {
		logic [31:0] query_time;
		logic [31:0] knot3;
		logic [31:0] knot2;
		logic [31:0] knot1;
		logic [31:0] knot0;
		logic [31:0] sample3;
		logic [31:0] sample2;
		logic [31:0] sample1;
		logic [31:0] sample0;
	} query_t;

	typedef struct packed {
		logic        saturated;
		status_t     status;
		logic [31:0] value;
	} interp_t;

	localparam longint QMAX = 64'sd2147483647;
	localparam longint QMIN = -64'sd2147483648;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [287:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;

	query_t pending_q[$];
	interp_t expected_q[$];
	int mismatches = 0;
	int sent = 0;
	int received = 0;
	int zero_cnt = 0;
	int outside_cnt = 0;
	int sat_cnt = 0;
	int idle_cycles = 0;
	bit allow_gaps = 1'b1;
	bit hold_send = 1'b0;
	int send_gap = 0;
	int recv_gap = 0;

	// per-item fault flags of the predictor
	bit clipped;
	bit div_by_zero;

	nonuniform_cubic_spline_eval_core dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// clamp a wide value to the Q16.16 range
	function automatic longint sat32(input longint v);
		if (v > QMAX) begin
			clipped = 1'b1;
			return QMAX;
		end
		if (v < QMIN) begin
			clipped = 1'b1;
			return QMIN;
		end
		return v;
	endfunction

	function automatic longint fx_sub(input longint a, input longint b);
		return sat32(a - b);
	endfunction

	function automatic longint fx_add(input longint a, input longint b);
		return sat32(a + b);
	endfunction

	// product shifted on its magnitude, truncating toward zero
	function automatic longint fx_mul(input longint a, input longint b);
		logic [127:0] m;
		logic [127:0] q;
		bit neg;
		neg = (a < 0) != (b < 0);
		m = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
		q = m >> 16;
		if (q > 128'(neg ? 64'd2147483648 : 64'd2147483647)) begin
			clipped = 1'b1;
			return neg ? QMIN : QMAX;
		end
		return neg ? -longint'(q) : longint'(q);
	endfunction

	// scaled quotient on magnitudes, truncating toward zero
	function automatic longint fx_div(input longint a, input longint b);
		logic [127:0] n;
		logic [127:0] q;
		bit neg;
		if (b == 0) begin
			div_by_zero = 1'b1;
			if (a == 0) return 0;
			clipped = 1'b1;
			return a > 0 ? QMAX : QMIN;
		end
		neg = (a < 0) != (b < 0);
		n = 128'(a < 0 ? -a : a) << 16;
		q = n / 128'(b < 0 ? -b : b);
		if (q > 128'(neg ? 64'd2147483648 : 64'd2147483647)) begin
			clipped = 1'b1;
			return neg ? QMIN : QMAX;
		end
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic interp_t newton_eval(input query_t it);
		interp_t r;
		longint f0, f1, f2, f3, t0, t1, t2, t3, t, acc;
		clipped = 1'b0;
		div_by_zero = 1'b0;
		f0 = longint'($signed(it.sample0));
		f1 = longint'($signed(it.sample1));
		f2 = longint'($signed(it.sample2));
		f3 = longint'($signed(it.sample3));
		t0 = longint'($signed(it.knot0));
		t1 = longint'($signed(it.knot1));
		t2 = longint'($signed(it.knot2));
		t3 = longint'($signed(it.knot3));
		t = longint'($signed(it.query_time));
		f3 = fx_div(fx_sub(f3, f2), fx_sub(t3, t2));
		f2 = fx_div(fx_sub(f2, f1), fx_sub(t2, t1));
		f1 = fx_div(fx_sub(f1, f0), fx_sub(t1, t0));
		f3 = fx_div(fx_sub(f3, f2), fx_sub(t3, t1));
		f2 = fx_div(fx_sub(f2, f1), fx_sub(t2, t0));
		f3 = fx_div(fx_sub(f3, f2), fx_sub(t3, t0));
		acc = fx_add(f2, fx_mul(fx_sub(t, t2), f3));
		acc = fx_add(f1, fx_mul(fx_sub(t, t1), acc));
		acc = fx_add(f0, fx_mul(fx_sub(t, t0), acc));
		r.value = acc[31:0];
		if (div_by_zero) r.status = ST_ZERO;
		else if (t < t0 || t > t3) r.status = ST_OUTSIDE;
		else r.status = ST_OK;
		r.saturated = clipped;
		return r;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(0, 5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom;
			default: return 32'($signed($urandom_range(0, 20'hfffff)) - 20'sh80000);
		endcase
	endfunction

	// mostly ordered knots with random spacing and a query mostly inside
	function automatic query_t well_formed();
		query_t it;
		int base;
		int step;
		int sp;
		sp = $urandom_range(0, 3);
		step = (sp == 0) ? 32'h100 : (sp == 1) ? 32'h10000 : 32'h80000;
		base = $signed($urandom_range(0, 32'h3fffff)) - 32'sh200000;
		it.sample0 = rand_word();
		it.sample1 = rand_word();
		it.sample2 = rand_word();
		it.sample3 = rand_word();
		it.knot0 = base;
		it.knot1 = it.knot0 + $urandom_range(1, step);
		it.knot2 = it.knot1 + $urandom_range(1, step);
		it.knot3 = it.knot2 + $urandom_range(1, step);
		if ($urandom_range(0, 9) < 8)
			it.query_time = it.knot0 + $urandom_range(0, it.knot3 - it.knot0);
		else
			it.query_time = rand_word();
		if ($urandom_range(0, 19) == 0) it.knot2 = it.knot1;
		if ($urandom_range(0, 29) == 0) it.knot3 = it.knot0;
		return it;
	endfunction

	function automatic query_t noise();
		query_t it;
		it = {$urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom, $urandom, $urandom};
		return it;
	endfunction

	// driver: present the next pending query, with random gaps
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			send_gap <= 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (s_axis_tvalid) begin
				expected_q.push_back(newton_eval(query_t'(s_axis_tdata)));
				sent <= sent + 1;
			end
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				s_axis_tvalid <= 1'b0;
			end else if (allow_gaps && $urandom_range(0, 15) == 0) begin
				send_gap <= $urandom_range(0, 7);
				s_axis_tvalid <= 1'b0;
			end else if (!hold_send && pending_q.size() > 0) begin
				s_axis_tdata <= pending_q.pop_front();
				s_axis_tvalid <= 1'b1;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// monitor: accept results with random stalls and compare
	always @(posedge clk or negedge arst_n) begin
		interp_t got;
		interp_t want;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = interp_t'(m_axis_tdata[34:0]);
				received <= received + 1;
				if (expected_q.size() == 0) begin
					mismatches <= mismatches + 1;
					if (mismatches < 10)
						$display("unexpected result %h", m_axis_tdata);
				end else begin
					want = expected_q.pop_front();
					if (want.status == ST_ZERO) zero_cnt <= zero_cnt + 1;
					if (want.status == ST_OUTSIDE) outside_cnt <= outside_cnt + 1;
					if (want.saturated) sat_cnt <= sat_cnt + 1;
					if (got !== want || m_axis_tdata[39:35] !== 5'd0) begin
						mismatches <= mismatches + 1;
						if (mismatches < 10)
							$display("mismatch: value %h/%h status %0d/%0d sat %b/%b",
								want.value, got.value, want.status, got.status,
								want.saturated, got.saturated);
					end
				end
			end
			if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				m_axis_tready <= 1'b0;
			end else if (allow_gaps && $urandom_range(0, 15) == 0) begin
				recv_gap <= $urandom_range(0, 7);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// watchdog: count cycles in which no transfer happens
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("watchdog expired");
			$display("** nonuniform_cubic_spline_eval_core: FAILED **");
			$finish;
		end
	end

	initial begin
		query_t it;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, zero spacing, outside query, reversed knots
		it = '{default: 32'h0};
		pending_q.push_back(it);
		it = '{32'h00018000, 32'h00030000, 32'h00020000, 32'h00010000, 32'h0,
			32'h00090000, 32'h00040000, 32'h00010000, 32'h0};
		pending_q.push_back(it);
		it.query_time = 32'h00050000;
		pending_q.push_back(it);
		it.query_time = 32'hffff0000;
		pending_q.push_back(it);
		it.knot2 = it.knot1;
		pending_q.push_back(it);
		it = '{default: 32'h7fffffff};
		pending_q.push_back(it);
		it = '{default: 32'h80000000};
		pending_q.push_back(it);
		it = '{32'h0, 32'h7fffffff, 32'h40000000, 32'h00000001, 32'h80000000,
			32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff};
		pending_q.push_back(it);
		it = '{32'h0, 32'h0, 32'h10000, 32'h20000, 32'h30000,
			32'h0, 32'h0, 32'h0, 32'h10000};
		pending_q.push_back(it);
		it = '{32'h0, 32'h1, 32'h2, 32'h3, 32'h4,
			32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000};
		pending_q.push_back(it);
		it = '{32'h0, 32'h30000, 32'h20000, 32'h10000, 32'h40000,
			32'h1, 32'hfffffff, 32'h1, 32'h80000000};
		pending_q.push_back(it);
		for (int i = 0; i < 8; i++) pending_q.push_back(noise());

		// pause the sender until the pipeline has drained
		wait (pending_q.size() == 0 && !s_axis_tvalid);
		hold_send = 1'b1;
		for (int i = 0; i < N_RANDOM; i++)
			pending_q.push_back($urandom_range(0, 9) < 8 ? well_formed() : noise());
		wait (expected_q.size() == 0 && sent == received);
		hold_send = 1'b0;

		wait (pending_q.size() < TAIL_ITEMS);
		allow_gaps = 1'b0;
		wait (pending_q.size() == 0 && !s_axis_tvalid);
		wait (expected_q.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);

		$display("covered %0d queries: %0d zero spacing, %0d outside range, %0d clipped",
			received, zero_cnt, outside_cnt, sat_cnt);
		$display("mismatches: %0d", mismatches);
		if (mismatches == 0 && expected_q.size() == 0 && sent == received)
			$display("** nonuniform_cubic_spline_eval_core: PASSED **");
		else
			$display("** nonuniform_cubic_spline_eval_core: FAILED **");
		$finish;
	end
endmodule
